// ----- hw/rtl/iol_pkg.sv -----
// Shared constants, codes and controller/datapath command types for the ordered list.
package iol_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W    = 3;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 7;

    localparam logic [KIND_W-1:0] REQ_INSERT   = 3'd0;
    localparam logic [KIND_W-1:0] REQ_REMOVE   = 3'd1;
    localparam logic [KIND_W-1:0] REQ_READ     = 3'd2;
    localparam logic [KIND_W-1:0] REQ_CONTAINS = 3'd3;
    localparam logic [KIND_W-1:0] REQ_DEDUP    = 3'd4;
    localparam logic [KIND_W-1:0] REQ_CLEAR    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        RD_IDX,
        RD_IDX_M1,
        RD_IDX_P1,
        RD_POS,
        RD_JDX
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_IDX_RD,
        WR_POS_VAL,
        WR_KEEP_CUR
    } wr_sel_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CNT,
        IDX_POS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        JDX_HOLD,
        JDX_IDX_P1,
        JDX_INC
    } jdx_op_t;

    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_ZERO,
        CNT_KEEP
    } cnt_op_t;

    typedef struct packed {
        logic                req_load;
        logic                rd_en;
        rd_sel_t             rd_sel;
        logic                wr_en;
        wr_sel_t             wr_sel;
        idx_op_t             idx_op;
        jdx_op_t             jdx_op;
        logic                keep_zero;
        logic                keep_inc;
        cnt_op_t             cnt_op;
        logic                cur_load;
        logic                data_load;
        logic                found_set;
        logic                status_set;
        logic [STATUS_W-1:0] status_val;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              pos_gt_cnt;
        logic              pos_eq_cnt;
        logic              pos_ge_cnt;
        logic              cnt_full;
        logic              cnt_zero;
        logic              idx_p1_lt_cnt;
        logic              idx_p2_lt_cnt;
        logic              idx_m1_eq_pos;
        logic              jdx_p1_lt_cnt;
        logic              rd_eq_val;
        logic              rd_eq_cur;
        logic              out_free;
    } sts_t;

endpackage

// ----- hw/rtl/iol_if.sv -----
// Request and response channel interfaces of the ordered list.
interface iol_req_if import iol_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] req_type;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output req_type, output position, output value,
                    input ready);
    modport sink (input valid, input req_type, input position, input value,
                  output ready);
endinterface

interface iol_rsp_if import iol_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VAL_W-1:0]     data_out;
    logic                 found;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] count;

    modport source (output valid, output data_out, output found, output status,
                    output count, input ready);
    modport sink (input valid, input data_out, input found, input status,
                  input count, output ready);
endinterface

// ----- hw/rtl/iol_dp.sv -----
// Datapath: entry memory, list count, walk indices, comparators and result registers.
module iol_dp import iol_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [KIND_W-1:0]    req_type,
    input  logic [POS_W-1:0]     req_position,
    input  logic [VAL_W-1:0]     req_value,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [VAL_W-1:0]     rsp_data_out,
    output logic                 rsp_found,
    output logic [STATUS_W-1:0]  rsp_status,
    output logic [CNT_OUT_W-1:0] rsp_count
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic [KIND_W-1:0]     kind_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [DATA_WIDTH-1:0] cur_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      jdx_reg, jdx_next;
    logic [CNT_W-1:0]      keep_reg;
    logic [DATA_WIDTH-1:0] data_reg;
    logic                  found_reg;
    logic [STATUS_W-1:0]   status_reg;

    logic                  out_valid_reg;
    logic [VAL_W-1:0]      out_data_reg;
    logic                  out_found_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [CNT_OUT_W-1:0]  out_count_reg;

    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [CNT_W-1:0]      idx_m1;
    logic [CNT_W:0]        idx_p1_w, idx_p2_w, jdx_p1_w, count_w;
    logic [CMP_W-1:0]      pos_ext, cnt_ext;

    assign idx_m1   = idx_reg - CNT_W'(1);
    assign idx_p1_w = {1'b0, idx_reg} + (CNT_W+1)'(1);
    assign idx_p2_w = {1'b0, idx_reg} + (CNT_W+1)'(2);
    assign jdx_p1_w = {1'b0, jdx_reg} + (CNT_W+1)'(1);
    assign count_w  = {1'b0, count_reg};
    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_ext  = CMP_W'(count_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:    rd_addr = ADDR_W'(idx_reg);
            RD_IDX_M1: rd_addr = ADDR_W'(idx_m1);
            RD_IDX_P1: rd_addr = ADDR_W'(idx_p1_w);
            RD_POS:    rd_addr = ADDR_W'(pos_reg);
            RD_JDX:    rd_addr = ADDR_W'(jdx_reg);
            default:   rd_addr = ADDR_W'(idx_reg);
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            WR_IDX_RD:
            begin
                wr_addr = ADDR_W'(idx_reg);
                wr_data = rdata_reg;
            end
            WR_POS_VAL:
            begin
                wr_addr = ADDR_W'(pos_reg);
                wr_data = val_reg;
            end
            WR_KEEP_CUR:
            begin
                wr_addr = ADDR_W'(keep_reg);
                wr_data = cur_reg;
            end
            default:
            begin
                wr_addr = ADDR_W'(idx_reg);
                wr_data = rdata_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_HOLD: idx_next = idx_reg;
            IDX_CNT:  idx_next = count_reg;
            IDX_POS:  idx_next = CNT_W'(pos_reg);
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_reg + CNT_W'(1);
            IDX_DEC:  idx_next = idx_m1;
            default:  idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.jdx_op)
            JDX_HOLD:   jdx_next = jdx_reg;
            JDX_IDX_P1: jdx_next = CNT_W'(idx_p1_w);
            JDX_INC:    jdx_next = CNT_W'(jdx_p1_w);
            default:    jdx_next = jdx_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_HOLD: count_next = count_reg;
            CNT_INC:  count_next = count_reg + CNT_W'(1);
            CNT_DEC:  count_next = count_reg - CNT_W'(1);
            CNT_ZERO: count_next = '0;
            CNT_KEEP: count_next = keep_reg;
            default:  count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        jdx_reg <= jdx_next;
        if (cmd.req_load)
        begin
            kind_reg   <= req_type;
            pos_reg    <= req_position;
            val_reg    <= DATA_WIDTH'(req_value);
            data_reg   <= '0;
            found_reg  <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.data_load)
            begin
                data_reg <= rdata_reg;
            end
            if (cmd.found_set)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.status_set)
            begin
                status_reg <= cmd.status_val;
            end
        end
        if (cmd.keep_zero)
        begin
            keep_reg <= '0;
        end
        else if (cmd.keep_inc)
        begin
            keep_reg <= keep_reg + CNT_W'(1);
        end
        if (cmd.cur_load)
        begin
            cur_reg <= rdata_reg;
        end
        if (cmd.out_load)
        begin
            out_data_reg   <= VAL_W'(data_reg);
            out_found_reg  <= found_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= CNT_OUT_W'(count_reg);
        end
    end

    assign sts.kind          = kind_reg;
    assign sts.pos_gt_cnt    = pos_ext > cnt_ext;
    assign sts.pos_eq_cnt    = pos_ext == cnt_ext;
    assign sts.pos_ge_cnt    = pos_ext >= cnt_ext;
    assign sts.cnt_full      = count_reg >= CNT_W'(CAPACITY);
    assign sts.cnt_zero      = count_reg == '0;
    assign sts.idx_p1_lt_cnt = idx_p1_w < count_w;
    assign sts.idx_p2_lt_cnt = idx_p2_w < count_w;
    assign sts.idx_m1_eq_pos = CMP_W'(idx_m1) == pos_ext;
    assign sts.jdx_p1_lt_cnt = jdx_p1_w < count_w;
    assign sts.rd_eq_val     = rdata_reg == val_reg;
    assign sts.rd_eq_cur     = rdata_reg == cur_reg;
    assign sts.out_free      = !out_valid_reg || rsp_ready;

    assign rsp_valid    = out_valid_reg;
    assign rsp_data_out = out_data_reg;
    assign rsp_found    = out_found_reg;
    assign rsp_status   = out_status_reg;
    assign rsp_count    = out_count_reg;

endmodule

// ----- hw/rtl/iol_ctrl.sv -----
// Controller: sequences each request as memory reads, writes and index steps.
module iol_ctrl import iol_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DECODE  = 5'd1;
    localparam logic [4:0] S_INS_RD  = 5'd2;
    localparam logic [4:0] S_INS_WR  = 5'd3;
    localparam logic [4:0] S_INS_PUT = 5'd4;
    localparam logic [4:0] S_REM_CAP = 5'd5;
    localparam logic [4:0] S_REM_RD  = 5'd6;
    localparam logic [4:0] S_REM_WR  = 5'd7;
    localparam logic [4:0] S_REM_END = 5'd8;
    localparam logic [4:0] S_RD_CAP  = 5'd9;
    localparam logic [4:0] S_CON_RD  = 5'd10;
    localparam logic [4:0] S_CON_CMP = 5'd11;
    localparam logic [4:0] S_DD_RDI  = 5'd12;
    localparam logic [4:0] S_DD_CUR  = 5'd13;
    localparam logic [4:0] S_DD_RDJ  = 5'd14;
    localparam logic [4:0] S_DD_CMP  = 5'd15;
    localparam logic [4:0] S_DD_KEEP = 5'd16;
    localparam logic [4:0] S_DD_NEXT = 5'd17;
    localparam logic [4:0] S_DD_END  = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    logic [4:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = RD_IDX;
        cmd.wr_sel     = WR_IDX_RD;
        cmd.idx_op     = IDX_HOLD;
        cmd.jdx_op     = JDX_HOLD;
        cmd.cnt_op     = CNT_HOLD;
        cmd.status_val = ST_OK;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.kind)
                    REQ_INSERT:
                    begin
                        if (sts.pos_gt_cnt)
                        begin
                            cmd.status_set = 1'b1;
                            cmd.status_val = ST_RANGE;
                            state_next     = S_DONE;
                        end
                        else if (sts.cnt_full)
                        begin
                            cmd.status_set = 1'b1;
                            cmd.status_val = ST_FULL;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_CNT;
                            state_next = sts.pos_eq_cnt ? S_INS_PUT : S_INS_RD;
                        end
                    end
                    REQ_REMOVE, REQ_READ:
                    begin
                        if (sts.pos_ge_cnt)
                        begin
                            cmd.status_set = 1'b1;
                            cmd.status_val = ST_RANGE;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_POS;
                            cmd.idx_op = IDX_POS;
                            state_next = (sts.kind == REQ_REMOVE) ? S_REM_CAP : S_RD_CAP;
                        end
                    end
                    REQ_CONTAINS:
                    begin
                        cmd.idx_op = IDX_ZERO;
                        state_next = sts.cnt_zero ? S_DONE : S_CON_RD;
                    end
                    REQ_DEDUP:
                    begin
                        cmd.idx_op    = IDX_ZERO;
                        cmd.keep_zero = 1'b1;
                        state_next    = sts.cnt_zero ? S_DONE : S_DD_RDI;
                    end
                    REQ_CLEAR:
                    begin
                        cmd.cnt_op = CNT_ZERO;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            // move entries up one place, top first
            S_INS_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX_M1;
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_IDX_RD;
                cmd.idx_op = IDX_DEC;
                state_next = sts.idx_m1_eq_pos ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_POS_VAL;
                cmd.cnt_op = CNT_INC;
                state_next = S_DONE;
            end
            // hold the removed entry, then close the gap
            S_REM_CAP:
            begin
                cmd.data_load = 1'b1;
                state_next    = sts.idx_p1_lt_cnt ? S_REM_RD : S_REM_END;
            end
            S_REM_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX_P1;
                state_next = S_REM_WR;
            end
            S_REM_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WR_IDX_RD;
                cmd.idx_op = IDX_INC;
                state_next = sts.idx_p2_lt_cnt ? S_REM_RD : S_REM_END;
            end
            S_REM_END:
            begin
                cmd.cnt_op = CNT_DEC;
                state_next = S_DONE;
            end
            S_RD_CAP:
            begin
                cmd.data_load = 1'b1;
                state_next    = S_DONE;
            end
            S_CON_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
                state_next = S_CON_CMP;
            end
            S_CON_CMP:
            begin
                if (sts.rd_eq_val)
                begin
                    cmd.found_set = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = sts.idx_p1_lt_cnt ? S_CON_RD : S_DONE;
                end
            end
            // keep an entry only if no later entry matches it
            S_DD_RDI:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_IDX;
                state_next = S_DD_CUR;
            end
            S_DD_CUR:
            begin
                cmd.cur_load = 1'b1;
                cmd.jdx_op   = JDX_IDX_P1;
                state_next   = sts.idx_p1_lt_cnt ? S_DD_RDJ : S_DD_KEEP;
            end
            S_DD_RDJ:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_JDX;
                state_next = S_DD_CMP;
            end
            S_DD_CMP:
            begin
                if (sts.rd_eq_cur)
                begin
                    state_next = S_DD_NEXT;
                end
                else
                begin
                    cmd.jdx_op = JDX_INC;
                    state_next = sts.jdx_p1_lt_cnt ? S_DD_RDJ : S_DD_KEEP;
                end
            end
            S_DD_KEEP:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WR_KEEP_CUR;
                cmd.keep_inc = 1'b1;
                state_next   = S_DD_NEXT;
            end
            S_DD_NEXT:
            begin
                cmd.idx_op = IDX_INC;
                state_next = sts.idx_p1_lt_cnt ? S_DD_RDI : S_DD_END;
            end
            S_DD_END:
            begin
                cmd.cnt_op = CNT_KEEP;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/indexed_ordered_list_core.sv -----
// Top level of the indexed ordered list: controller, datapath and checks.
//
// A bounded list of up to CAPACITY values kept in position order. Requests
// arrive as beats on req (req_type, position, value); each gives exactly one
// beat on rsp (data_out, found, status, count), in request order.
// One request is worked at a time: req.ready is high only while the
// controller is idle, and the entry memory (one read and one write port,
// registered read) sets the pace. The next request is taken on the cycle
// after its result is registered. A result waits in the output register
// while rsp.ready is low; the next request is still accepted and worked,
// and only its own result holds until the register drains. Reset empties
// the list at once and drops any result in flight; the entry memory needs
// no clearing pass.
module indexed_ordered_list_core import iol_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic        clk,
    input logic        rst_n,
    iol_req_if.sink    req,
    iol_rsp_if.source  rsp
);

    cmd_t cmd;
    sts_t sts;
    logic req_ready;

    assign req.ready = req_ready;

    iol_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    iol_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_type     (req.req_type),
        .req_position (req.position),
        .req_value    (req.value),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .rsp_data_out (rsp.data_out),
        .rsp_found    (rsp.found),
        .rsp_status   (rsp.status),
        .rsp_count    (rsp.count)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req_ready |=> !req_ready)
        else $error("request taken while the previous one is still at work");

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> !req_ready)
        else $error("entry memory written while idle");

    a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.found |-> rsp.status == ST_OK && rsp.data_out == '0)
        else $error("found beat carries a status or data");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_FULL |-> rsp.count == CNT_OUT_W'(CAPACITY))
        else $error("full reported below capacity");

endmodule

// ----- tb/sv/tb_indexed_ordered_list_core.sv -----
// Self-checking testbench for the indexed ordered list: directed table, random episodes, predictor.
module tb_indexed_ordered_list_core;
    import iol_pkg::*;

    localparam int LIST_CAP     = CAPACITY_DEF;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1930;
    localparam int HOLD_AT      = 200;
    localparam int LONG_HOLD    = 500;
    localparam int DRAIN_CYCLES = 40;
    // Watchdog bound on the run; even a run heavy in full-list duplicate sweeps
    // stays well inside it.
    localparam int CYCLE_LIMIT  = 4_000_000;

    localparam logic [KIND_W-1:0] REQ_UNUSED_6 = 3'd6;
    localparam logic [KIND_W-1:0] REQ_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [VAL_W-1:0]     data_out;
        logic                 found;
        logic [STATUS_W-1:0]  status;
        logic [CNT_OUT_W-1:0] count;
    } list_result_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;
        logic              typed;
        list_result_t      res;
    } list_row_t;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED
    } fill_mode_t;

    localparam list_result_t NO_RES = '0;

    // Typed results are the obvious ones: empty list, first inserts, bad positions, clear.
    localparam list_row_t DIRECTED_ROWS [24] = '{
        '{REQ_READ,     7'd0,   32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_RANGE, 7'd0}},
        '{REQ_REMOVE,   7'd0,   32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_RANGE, 7'd0}},
        '{REQ_CONTAINS, 7'd0,   32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_OK,    7'd0}},
        '{REQ_DEDUP,    7'd0,   32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_OK,    7'd0}},
        '{REQ_CLEAR,    7'd0,   32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_OK,    7'd0}},
        '{REQ_INSERT,   7'd1,   32'h0000_0007, 1'b1, '{32'd0, 1'b0, ST_RANGE, 7'd0}},
        '{REQ_INSERT,   7'd0,   32'hFFFF_FFFF, 1'b1, '{32'd0, 1'b0, ST_OK,    7'd1}},
        '{REQ_INSERT,   7'd0,   32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_OK,    7'd2}},
        '{REQ_INSERT,   7'd2,   32'h8000_0000, 1'b0, NO_RES},
        '{REQ_INSERT,   7'd1,   32'hFFFF_FFFF, 1'b0, NO_RES},
        '{REQ_READ,     7'd3,   32'h0000_0000, 1'b0, NO_RES},
        '{REQ_READ,     7'd0,   32'hFFFF_FFFF, 1'b0, NO_RES},
        '{REQ_CONTAINS, 7'd0,   32'hFFFF_FFFF, 1'b0, NO_RES},
        '{REQ_CONTAINS, 7'd127, 32'h1234_5678, 1'b0, NO_RES},
        '{REQ_READ,     7'd127, 32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_RANGE, 7'd4}},
        '{REQ_INSERT,   7'd127, 32'h5A5A_5A5A, 1'b1, '{32'd0, 1'b0, ST_RANGE, 7'd4}},
        '{REQ_REMOVE,   7'd4,   32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_RANGE, 7'd4}},
        '{REQ_UNUSED_6, 7'd127, 32'hFFFF_FFFF, 1'b0, NO_RES},
        '{REQ_UNUSED_7, 7'd1,   32'h0000_0000, 1'b0, NO_RES},
        '{REQ_DEDUP,    7'd0,   32'h0000_0000, 1'b0, NO_RES},
        '{REQ_REMOVE,   7'd0,   32'h0000_0000, 1'b0, NO_RES},
        '{REQ_REMOVE,   7'd1,   32'h0000_0000, 1'b0, NO_RES},
        '{REQ_INSERT,   7'd2,   32'h0000_0005, 1'b0, NO_RES},
        '{REQ_CLEAR,    7'd0,   32'h0000_0000, 1'b1, '{32'd0, 1'b0, ST_OK,    7'd0}}
    };

    // Cumulative percentages: insert, remove, read, contains, dedup, clear, unused.
    localparam int KIND_CUM [3][7] = '{
        '{64, 72, 82, 92, 96, 97, 100},
        '{10, 60, 72, 84, 92, 97, 100},
        '{35, 55, 70, 85, 93, 97, 100}
    };

    localparam logic [VAL_W-1:0] VALUE_POOL [6] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h0000_0001, 32'hA5A5_A5A5, 32'h5A5A_5A5A
    };

    logic clk;
    logic rst_n;

    iol_req_if req_ch ();
    iol_rsp_if rsp_ch ();

    indexed_ordered_list_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted list contents
    logic [VAL_W-1:0] list_mem [LIST_CAP];
    int               list_len;

    list_result_t pending_q [$];

    int fail_count;
    int requests_sent;
    int results_checked;
    int full_hits;
    int dedup_sweeps;
    int peak_len;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_request;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic list_result_t apply_list_request(input logic [KIND_W-1:0] kind,
                                                        input logic [POS_W-1:0] pos,
                                                        input logic [VAL_W-1:0] val);
        list_result_t res;
        int           at;
        int           keep;
        bit           later;
        res = '0;
        at  = int'(pos);
        case (kind)
            REQ_INSERT:
            begin
                if (at > list_len)
                    res.status = ST_RANGE;
                else if (list_len >= LIST_CAP)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > at; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[at] = val;
                    list_len++;
                end
            end
            REQ_REMOVE:
            begin
                if (at >= list_len)
                    res.status = ST_RANGE;
                else
                begin
                    res.data_out = list_mem[at];
                    for (int i = at; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            REQ_READ:
            begin
                if (at >= list_len)
                    res.status = ST_RANGE;
                else
                    res.data_out = list_mem[at];
            end
            REQ_CONTAINS:
            begin
                for (int i = 0; i < list_len; i++)
                    if (list_mem[i] == val)
                        res.found = 1'b1;
            end
            REQ_DEDUP:
            begin
                // keep the last copy of each value; writes never overtake the scan
                keep = 0;
                for (int i = 0; i < list_len; i++)
                begin
                    later = 1'b0;
                    for (int j = i + 1; j < list_len; j++)
                        if (list_mem[j] == list_mem[i])
                            later = 1'b1;
                    if (!later)
                    begin
                        list_mem[keep] = list_mem[i];
                        keep++;
                    end
                end
                list_len = keep;
            end
            REQ_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        res.count = CNT_OUT_W'(list_len);
        return res;
    endfunction

    function automatic logic [KIND_W-1:0] pick_kind(input fill_mode_t mode);
        int r;
        r = $urandom_range(99);
        if (r < KIND_CUM[mode][0]) return REQ_INSERT;
        if (r < KIND_CUM[mode][1]) return REQ_REMOVE;
        if (r < KIND_CUM[mode][2]) return REQ_READ;
        if (r < KIND_CUM[mode][3]) return REQ_CONTAINS;
        if (r < KIND_CUM[mode][4]) return REQ_DEDUP;
        if (r < KIND_CUM[mode][5]) return REQ_CLEAR;
        return ($urandom_range(1) == 0) ? REQ_UNUSED_6 : REQ_UNUSED_7;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input logic [KIND_W-1:0] kind);
        int r;
        r = $urandom_range(99);
        if (kind == REQ_INSERT)
        begin
            if (r < 85)
                return POS_W'($urandom_range(list_len));
            if (r < 92)
                return POS_W'(list_len);
        end
        else if ((kind == REQ_REMOVE || kind == REQ_READ) && list_len > 0 && r < 85)
            return POS_W'($urandom_range(list_len - 1));
        return POS_W'($urandom_range(127));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value(input logic [KIND_W-1:0] kind);
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return VALUE_POOL[$urandom_range(5)];
        if (kind == REQ_CONTAINS && list_len > 0 && r < 70)
            return list_mem[$urandom_range(list_len - 1)];
        return $urandom;
    endfunction

    // Offer one beat; record its expected result once it is taken.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val, input logic typed,
                                input list_result_t typed_res);
        list_result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.position <= pos;
        req_ch.value    <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        res = apply_list_request(kind, pos, val);
        pending_q.push_back(typed ? typed_res : res);
        requests_sent++;
        if (res.status == ST_FULL)
            full_hits++;
        if (kind == REQ_DEDUP)
            dedup_sweeps++;
        if (list_len > peak_len)
            peak_len = list_len;
        @(negedge clk);
    endtask

    task automatic check_result(input list_result_t want, input list_result_t got);
        if (got.data_out !== want.data_out)
        begin
            $error("data_out: expected %h, got %h", want.data_out, got.data_out);
            fail_count++;
        end
        if (got.found !== want.found)
        begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fail_count++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
        end
        if (got.count !== want.count)
        begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result beat with nothing expected: data_out %h count %0d",
                       rsp_ch.data_out, rsp_ch.count);
                fail_count++;
            end
            else
            begin
                check_result(pending_q.pop_front(),
                             '{rsp_ch.data_out, rsp_ch.found, rsp_ch.status, rsp_ch.count});
                results_checked++;
            end
        end
    end

    // Result side: random back-pressure, plus one long hold on request.
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_left    = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("watchdog: run stopped after %0d cycles, %0d results outstanding",
                 cycle_count, pending_q.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        fill_mode_t        mode;
        int                mode_left;
        int                rand_done;
        bit                hold_fired;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  val;

        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = '0;
        req_ch.position = '0;
        req_ch.value    = '0;
        hold_request    = 1'b0;
        fail_count      = 0;
        requests_sent   = 0;
        results_checked = 0;
        full_hits       = 0;
        dedup_sweeps    = 0;
        peak_len        = 0;
        list_len        = 0;
        send_idle_pct   = 17;
        recv_idle_pct   = 62;
        rand_done       = 0;
        hold_fired      = 1'b0;
        mode            = MODE_GROW;
        mode_left       = 120;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_ROWS[r])
            send_request(DIRECTED_ROWS[r].kind, DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].val,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);

        while (rand_done < RANDOM_ITEMS)
        begin
            if (mode_left == 0)
            begin
                mode      = fill_mode_t'($urandom_range(2));
                mode_left = $urandom_range(40, 160);
            end
            mode_left--;
            if (rand_done < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 17;
                recv_idle_pct = 62;
            end
            else if (rand_done < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 62;
                recv_idle_pct = 17;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // stall the result side for a long stretch and keep offering beats
            if (rand_done == HOLD_AT && !hold_fired)
            begin
                hold_fired   = 1'b1;
                hold_request = 1'b1;
            end
            kind = pick_kind(mode);
            pos  = pick_position(kind);
            val  = pick_value(kind);
            send_request(kind, pos, val, 1'b0, NO_RES);
            if (kind <= REQ_CLEAR)
                rand_done++;
        end
        req_ch.valid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests over three back-pressure mixes; %0d results checked.",
                 requests_sent, results_checked);
        $display("List peaked at %0d entries, %0d inserts refused as full, %0d dedup sweeps.",
                 peak_len, full_hits, dedup_sweeps);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
